>>> sv/telemetry_frame_receiver_crc16_macros.svh
// Assertion macros for the telemetry frame receiver.
// Used by the modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef TELEMETRY_FRAME_RECEIVER_CRC16_MACROS_SVH
`define TELEMETRY_FRAME_RECEIVER_CRC16_MACROS_SVH
`ifndef SYNTH
`define TFR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tfr assertion failed");
`define TFR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tfr assertion failed");
`else
`define TFR_ASSERT_IMP(lbl, ante, cons)
`define TFR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/tfr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the telemetry frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none
package tfr_pkg;

	localparam logic [7:0]  SYNC_BYTE   = 8'hFE;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  CMD_RESET   = 8'h25;
	// Payload bytes 0..25 hold the command byte and the telemetry fields.
	localparam int          STORE_BYTES = 26;

	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_SYNC2 = 4'b0010,
		PH_LEN   = 4'b0100,
		PH_DATA  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_BAD_CMD = 2'd2,
		ST_BAD_CRC = 2'd3
	} status_t;

	typedef struct packed {
		status_t            status;
		logic signed [7:0]  vel_x;
		logic signed [7:0]  vel_y;
		logic signed [7:0]  vel_turn;
		logic [7:0]         motor_state;
		logic [7:0]         motor_fault;
		logic [7:0]         battery_raw;
		logic [7:0]         enable_state;
		logic [47:0]        accel_packed;
		logic [47:0]        gyro_packed;
		logic [47:0]        attitude_packed;
	} result_t;

	// One byte of the reflected CRC-16, eight shift steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// CRC after both sync bytes is fixed.
	localparam logic [15:0] CRC_AFTER_SYNC = crc_byte(crc_byte(CRC_INIT, SYNC_BYTE), SYNC_BYTE);

endpackage
`default_nettype wire

>>> sv/telemetry_frame_receiver_crc16.sv
// Telemetry frame receiver: deframes 0xFE 0xFE sync, length, payload and CRC-16 bytes.
// A result is registered: the byte that closes its frame passes the input stage, then the result register.
// Throughput: one byte beat per cycle, set by the combinational CRC byte update; a held
// result stalls the input only when the staged byte would emit another result.
// Reset (arst_n low) returns to sync hunting, presets the CRC to 0xFFFF, empties the
// result register and sets the command byte to 0x25; needs tfr_pkg, tfr_parser, tfr_out_reg.
`default_nettype none
module telemetry_frame_receiver_crc16 #(
	parameter int PAYLOAD_BYTES = 28
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [7:0]         cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              frame_status,
	output logic signed [7:0]       vel_x,
	output logic signed [7:0]       vel_y,
	output logic signed [7:0]       vel_turn,
	output logic [7:0]              motor_state,
	output logic [7:0]              motor_fault,
	output logic [7:0]              battery_raw,
	output logic [7:0]              enable_state,
	output logic [47:0]             accel_packed,
	output logic [47:0]             gyro_packed,
	output logic [47:0]             attitude_packed
);

	// Expected command byte; rewrite it only while no frame is in flight (the block does not enforce this).
	logic [7:0] report_command_q;

	// Input stage: one received byte waiting for the parser.
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	logic             step;
	logic             produce;
	logic             out_free;
	logic             in_accept;
	tfr_pkg::result_t res_comb;
	tfr_pkg::result_t res_q;

	// The parser consumes the staged byte unless that byte would emit a result
	// while the result register is still held by a stalled consumer. Bytes that
	// emit nothing keep flowing even when the output side is blocked.
	assign step      = valid_s1 && (!produce || out_free);
	assign in_stall  = valid_s1 && !step;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_command_q <= tfr_pkg::CMD_RESET;
		end else if (cfg_wr_en) begin
			report_command_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) rx_byte_s1 <= rx_byte;
	end

	tfr_parser #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.rx_byte_s1     (rx_byte_s1),
		.report_command (report_command_q),
		.produce        (produce),
		.res            (res_comb)
	);

	tfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && produce),
		.res_in    (res_comb),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	// Unpack the result register onto the individual field ports.
	assign frame_status    = 2'(res_q.status);
	assign vel_x           = res_q.vel_x;
	assign vel_y           = res_q.vel_y;
	assign vel_turn        = res_q.vel_turn;
	assign motor_state     = res_q.motor_state;
	assign motor_fault     = res_q.motor_fault;
	assign battery_raw     = res_q.battery_raw;
	assign enable_state    = res_q.enable_state;
	assign accel_packed    = res_q.accel_packed;
	assign gyro_packed     = res_q.gyro_packed;
	assign attitude_packed = res_q.attitude_packed;

endmodule
`default_nettype wire

>>> sv/tfr_parser.sv
// Frame parser: sync hunt, length check, payload capture, CRC and status decision.
// Depends on tfr_pkg and the assertion macro header.
`default_nettype none
`include "telemetry_frame_receiver_crc16_macros.svh"
module tfr_parser #(
	parameter int PAYLOAD_BYTES = 28
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      rx_byte_s1,
	input  wire logic [7:0]      report_command,
	output logic                 produce,
	output tfr_pkg::result_t     res
);

	localparam int IW = $clog2(PAYLOAD_BYTES);

	tfr_pkg::phase_t phase_q, phase_d;
	logic [IW-1:0]   idx_q, idx_d;
	logic [15:0]     crc_q, crc_d;
	logic [15:0]     crc_upd;
	logic [7:0]      store_q [tfr_pkg::STORE_BYTES];
	logic [7:0]      crc_hi_q;

	assign crc_upd = tfr_pkg::crc_byte(crc_q, rx_byte_s1);

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		crc_d   = crc_q;
		produce = 1'b0;
		res     = '0;
		unique case (phase_q)
			tfr_pkg::PH_HUNT: begin
				if (rx_byte_s1 == tfr_pkg::SYNC_BYTE) phase_d = tfr_pkg::PH_SYNC2;
			end
			tfr_pkg::PH_SYNC2: begin
				if (rx_byte_s1 == tfr_pkg::SYNC_BYTE) begin
					crc_d   = tfr_pkg::CRC_AFTER_SYNC;
					phase_d = tfr_pkg::PH_LEN;
				end else begin
					phase_d = tfr_pkg::PH_HUNT;
				end
			end
			tfr_pkg::PH_LEN: begin
				if (rx_byte_s1 != 8'(PAYLOAD_BYTES)) begin
					phase_d    = tfr_pkg::PH_HUNT;
					produce    = 1'b1;
					res.status = tfr_pkg::ST_BAD_LEN;
				end else begin
					crc_d   = crc_upd;
					idx_d   = '0;
					phase_d = tfr_pkg::PH_DATA;
				end
			end
			tfr_pkg::PH_DATA: begin
				// The two trailing CRC bytes are not part of the checked range.
				if (idx_q < IW'(PAYLOAD_BYTES - 2)) crc_d = crc_upd;
				if (idx_q == IW'(PAYLOAD_BYTES - 1)) begin
					phase_d = tfr_pkg::PH_HUNT;
					idx_d   = '0;
					produce = 1'b1;
					if (store_q[0] != report_command) begin
						res.status = tfr_pkg::ST_BAD_CMD;
					end else if ({crc_hi_q, rx_byte_s1} != crc_q) begin
						res.status = tfr_pkg::ST_BAD_CRC;
					end else begin
						res.status          = tfr_pkg::ST_OK;
						res.vel_x           = store_q[1];
						res.vel_y           = store_q[2];
						res.vel_turn        = store_q[3];
						res.motor_state     = store_q[4];
						res.motor_fault     = store_q[5];
						res.battery_raw     = store_q[6];
						res.enable_state    = store_q[7];
						res.accel_packed    = {store_q[8], store_q[9], store_q[10],
							store_q[11], store_q[12], store_q[13]};
						res.gyro_packed     = {store_q[14], store_q[15], store_q[16],
							store_q[17], store_q[18], store_q[19]};
						res.attitude_packed = {store_q[20], store_q[21], store_q[22],
							store_q[23], store_q[24], store_q[25]};
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			default: begin
				phase_d = tfr_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tfr_pkg::PH_HUNT;
			idx_q   <= '0;
			crc_q   <= tfr_pkg::CRC_INIT;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			crc_q   <= crc_d;
		end
	end

	// Payload bytes land at fixed places; only the current frame's bytes are read.
	always_ff @(posedge clk) begin
		if (step && phase_q == tfr_pkg::PH_DATA) begin
			for (int i = 0; i < tfr_pkg::STORE_BYTES; i++) begin
				if (idx_q == IW'(i)) store_q[i] <= rx_byte_s1;
			end
			if (idx_q == IW'(PAYLOAD_BYTES - 2)) crc_hi_q <= rx_byte_s1;
		end
	end

	`TFR_ASSERT_IMP(a_idx_in_range, phase_q == tfr_pkg::PH_DATA, idx_q <= IW'(PAYLOAD_BYTES - 1))
	`TFR_ASSERT_IMP(a_result_phase, step && produce, phase_q == tfr_pkg::PH_LEN || phase_q == tfr_pkg::PH_DATA)
	`TFR_ASSERT_IMP(a_reject_zero, produce && res.status != tfr_pkg::ST_OK, res.vel_x == 8'sd0 && res.accel_packed == 48'd0 && res.attitude_packed == 48'd0)
	`TFR_ASSERT_NXT(a_hunt_stays, step && phase_q == tfr_pkg::PH_HUNT && rx_byte_s1 != tfr_pkg::SYNC_BYTE, phase_q == tfr_pkg::PH_HUNT)
	`TFR_ASSERT_NXT(a_len_to_data, step && phase_q == tfr_pkg::PH_LEN && rx_byte_s1 == 8'(PAYLOAD_BYTES), phase_q == tfr_pkg::PH_DATA && idx_q == '0)

endmodule
`default_nettype wire

>>> sv/tfr_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on tfr_pkg for the result type.
`default_nettype none
module tfr_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire tfr_pkg::result_t  res_in,
	input  wire logic              out_stall,
	output logic                   out_free,
	output logic                   out_valid,
	output tfr_pkg::result_t       res_q
);

	logic out_valid_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res_in;
	end

endmodule
`default_nettype wire
